[design/ust_pkg.sv]
// shared types and constants for the unsorted set table
package ust_pkg;

	localparam int REQ_W   = 2;
	localparam int VALUE_W = 32;
	localparam int COUNT_W = 7;

	// request codes
	typedef enum logic [REQ_W-1:0] {
		OP_ADD      = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_CONTAINS = 2'd2,
		OP_CLEAR    = 2'd3
	} req_t;

	// result status codes
	localparam logic STATUS_OK   = 1'b0;
	localparam logic STATUS_FULL = 1'b1;

	// sequencer states, one-hot
	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_READ = 4'b0010,
		ST_CMP  = 4'b0100,
		ST_MOVE = 4'b1000
	} state_t;

endpackage

[design/unsorted_set_table_unit.sv]
// unsorted set table: entry memory, scan sequencer and shared comparator
//
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------------------
//  request  | start in, busy out   | req_type, value
//  result   | done out (strobe)    | status, found, entry_count, is_empty
//
// a request beat is taken at a rising edge with start high and busy low.
// add and clear finish at once: done strobes in the next cycle, busy stays low.
// contains and remove scan the entries one by one through the single memory
// read port and one comparator, reading then comparing each entry visited; a
// copy removed is overwritten by moving the last entry in, which is rescanned.
// done follows the final step.
// arst_n empties the table; entries hold old bits but are never read unwritten.
// done is high for one cycle only, the receiver cannot stall it.
module unsorted_set_table_unit #(
	parameter int CAPACITY = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [ust_pkg::REQ_W-1:0]        req_type,
	input  logic signed [ust_pkg::VALUE_W-1:0] value,
	output logic                             done,
	output logic                             status,
	output logic                             found,
	output logic [ust_pkg::COUNT_W-1:0]      entry_count,
	output logic                             is_empty
);

	import ust_pkg::*;

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	state_t               state_q;
	req_t                 op_q;
	logic [CNT_W-1:0]     cnt_q;
	logic [CNT_W-1:0]     idx_q;
	logic [CNT_W-1:0]     cnt_dec;
	logic                 done_q;
	logic                 status_q;
	logic                 found_q;
	logic [VALUE_W-1:0]   val_q;
	logic [VALUE_W-1:0]   rd_data_q;
	logic [VALUE_W-1:0]   mem [CAPACITY];

	logic                 accept;
	logic                 full;
	logic                 match;
	logic                 idx_in_use;
	logic                 mem_we;
	logic                 mem_re;
	logic [IDX_W-1:0]     wr_addr;
	logic [IDX_W-1:0]     rd_addr;
	logic [VALUE_W-1:0]   wr_data;
	logic [CNT_W+COUNT_W-1:0] cnt_ext;

	// request beat and shared comparator
	assign accept     = start && (state_q == ST_IDLE);
	assign full       = (cnt_q >= CNT_W'(CAPACITY));
	assign match      = (rd_data_q == val_q);
	assign idx_in_use = (idx_q < cnt_q);
	assign cnt_dec    = cnt_q - CNT_W'(1);

	// memory port control
	always_comb begin
		mem_we  = 1'b0;
		mem_re  = 1'b0;
		wr_addr = idx_q[IDX_W-1:0];
		rd_addr = idx_q[IDX_W-1:0];
		wr_data = rd_data_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && (req_t'(req_type) == OP_ADD) && !full) begin
					mem_we  = 1'b1;
					wr_addr = cnt_q[IDX_W-1:0];
					wr_data = value;
				end
			end
			ST_READ: begin
				mem_re = idx_in_use;
			end
			ST_CMP: begin
				// fetch the last entry to fill the freed slot
				if (match && (op_q == OP_REMOVE)) begin
					mem_re  = 1'b1;
					rd_addr = cnt_dec[IDX_W-1:0];
				end
			end
			ST_MOVE: begin
				mem_we = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	// entry memory and request value
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		if (mem_re) begin
			rd_data_q <= mem[rd_addr];
		end
		if (accept) begin
			val_q <= value;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			op_q     <= OP_ADD;
			cnt_q    <= '0;
			idx_q    <= '0;
			done_q   <= 1'b0;
			status_q <= STATUS_OK;
			found_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q     <= req_t'(req_type);
						idx_q    <= '0;
						status_q <= STATUS_OK;
						found_q  <= 1'b0;
						case (req_t'(req_type))
							OP_ADD: begin
								done_q <= 1'b1;
								if (full) begin
									status_q <= STATUS_FULL;
								end else begin
									cnt_q <= cnt_q + CNT_W'(1);
								end
							end
							OP_CLEAR: begin
								done_q <= 1'b1;
								cnt_q  <= '0;
							end
							default: begin
								state_q <= ST_READ;
							end
						endcase
					end
				end
				ST_READ: begin
					if (idx_in_use) begin
						state_q <= ST_CMP;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				ST_CMP: begin
					if (match) begin
						found_q <= 1'b1;
						if (op_q == OP_REMOVE) begin
							cnt_q   <= cnt_dec;
							state_q <= ST_MOVE;
						end else begin
							state_q <= ST_IDLE;
							done_q  <= 1'b1;
						end
					end else begin
						idx_q   <= idx_q + CNT_W'(1);
						state_q <= ST_READ;
					end
				end
				ST_MOVE: begin
					// rescan the filled slot
					state_q <= ST_READ;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result beat
	assign cnt_ext     = {{COUNT_W{1'b0}}, cnt_q};
	assign busy        = (state_q != ST_IDLE);
	assign done        = done_q;
	assign status      = status_q;
	assign found       = found_q;
	assign entry_count = cnt_ext[COUNT_W-1:0];
	assign is_empty    = (cnt_q == '0);

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count beyond capacity");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while sequencer busy");

	a_contains_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP && match && op_q == OP_CONTAINS) |=> (done && found))
		else $error("contains hit did not report found");

	a_remove_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP && match && op_q == OP_REMOVE)
		|=> (cnt_q == $past(cnt_dec)))
		else $error("remove did not shrink the table by one");

	a_short_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (req_t'(req_type) == OP_ADD || req_t'(req_type) == OP_CLEAR))
		|=> (done && !busy))
		else $error("add or clear did not finish in one cycle");

endmodule
